FILE: rtl/dat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dat_pkg
// Shared types and codes for the double-array trie step block.
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int BASE_W  = 13;
  localparam int CHECK_W = 12;
  localparam int POS_W   = 12;
  localparam int INDEX_W = 12;
  localparam int STAT_W  = 2;

  localparam logic [POS_W-1:0] ROOT_SLOT = 12'd1;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_MISS       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INNER      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_WORD_END   = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_WRITE_DONE = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic busy;
    logic clear;
    logic accept;
    logic resp;
  } ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/dat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dat_ram
// Generic single-port synchronous RAM, registered read (read-first).
// ----------------------------------------------------------------------------
module dat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/dat_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dat_seq
// Command sequencer: post-reset clearing sweep, accept and response phases.
// ----------------------------------------------------------------------------
module dat_seq #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output dat_pkg::ctrl_t                      ctrl_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      clr_addr_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  dat_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      dat_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == CLR_LAST) begin
          state_d = dat_pkg::ST_IDLE;
        end
      end
      dat_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = dat_pkg::ST_RESP;
        end
      end
      dat_pkg::ST_RESP: begin
        state_d = dat_pkg::ST_IDLE;
      end
      default: begin
        state_d = dat_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      dat_pkg::ST_CLEAR: begin
        ctrl_o.busy  = 1'b1;
        ctrl_o.clear = 1'b1;
      end
      dat_pkg::ST_IDLE: begin
        ctrl_o.accept = start_i;
      end
      dat_pkg::ST_RESP: begin
        ctrl_o.busy = 1'b1;
        ctrl_o.resp = 1'b1;
      end
      default: begin
        ctrl_o.busy = 1'b1;
      end
    endcase
  end

  assign clr_addr_o = clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dat_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/double_array_trie_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_array_trie_step
// Double-array trie walker: loads table entries and steps one symbol code.
// ----------------------------------------------------------------------------
// A command is taken on the edge where start is high and busy is low, and
// its result is shown on the following cycle with done_o high for that one
// cycle only (the receiver cannot stall, so sample it then). busy is high
// during that result cycle, so a new command cannot be taken until the
// result has been shown; the entry memory has a registered read, which the
// step must wait on before it can compare check and base. After reset busy
// stays high while the base/check memory is swept to zero, one entry per
// cycle. The data-id memory is not cleared: a word-end hit on a slot whose
// data id was never written returns an undefined data id.
// ----------------------------------------------------------------------------
module double_array_trie_step #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int CODE_WIDTH    = 8,
  parameter int DATA_ID_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                command_i,
  input  wire logic        [dat_pkg::INDEX_W-1:0]  entry_index_i,
  input  wire logic signed [dat_pkg::BASE_W-1:0]   entry_base_i,
  input  wire logic        [dat_pkg::CHECK_W-1:0]  entry_check_i,
  input  wire logic        [DATA_ID_WIDTH-1:0]     entry_data_id_i,
  input  wire logic        [CODE_WIDTH-1:0]        symbol_code_i,
  output logic                                     done_o,
  output logic             [dat_pkg::STAT_W-1:0]   status_o,
  output logic             [dat_pkg::POS_W-1:0]    position_o,
  output logic             [DATA_ID_WIDTH-1:0]     found_data_id_o
);

  localparam int BW = dat_pkg::BASE_W;
  localparam int CW = dat_pkg::CHECK_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  // position register must hold any slot index
  localparam int PW = (AW > dat_pkg::POS_W) ? AW : dat_pkg::POS_W;
  // target = |base| + code, one carry bit over the wider operand
  localparam int TW = ((BW > CODE_WIDTH) ? BW : CODE_WIDTH) + 1;
  localparam int EW = BW + CW;

  dat_pkg::ctrl_t ctrl;
  logic [AW-1:0]  clr_addr;

  // walk state
  logic [PW-1:0] pos_q, pos_d;
  logic [BW-1:0] cur_base_q, cur_base_d;   // copy of base[pos]
  logic [BW-1:0] root_base_q, root_base_d; // copy of base[root]

  // command held over the response cycle
  logic          cmd_q;
  logic          tgt_ok_q;
  logic [PW-1:0] tgt_q;

  logic [BW-1:0] base_mag;
  logic [TW-1:0] tgt;
  logic [31:0]   tgt_ext, idx_ext;
  logic          tgt_ok, idx_ok, wr_cmd, wr_en;

  logic [AW-1:0]            mem_addr;
  logic                     ent_we;
  logic [EW-1:0]            ent_wdata, ent_rdata;
  logic [DATA_ID_WIDTH-1:0] did_rdata;

  logic [BW-1:0] rd_base;
  logic [CW-1:0] rd_check;
  logic          hit, word_end;

  dat_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .ctrl_o    (ctrl),
    .clr_addr_o(clr_addr)
  );

  // --- address generation ---------------------------------------------------
  always_comb begin
    // magnitude of the stored base; the most negative code gives 2^(BW-1)
    base_mag = cur_base_q[BW-1] ? (~cur_base_q + BW'(1)) : cur_base_q;
    tgt      = TW'(base_mag) + TW'(symbol_code_i);
    tgt_ext  = 32'(tgt);
    tgt_ok   = tgt_ext < 32'(TABLE_DEPTH);
    idx_ext  = 32'(entry_index_i);
    idx_ok   = idx_ext < 32'(TABLE_DEPTH);
    wr_cmd   = ctrl.accept && (command_i == dat_pkg::CMD_WRITE);
    wr_en    = wr_cmd && idx_ok;

    if (ctrl.clear) begin
      mem_addr = clr_addr;
    end else if (command_i == dat_pkg::CMD_WRITE) begin
      mem_addr = idx_ext[AW-1:0];
    end else begin
      mem_addr = tgt_ext[AW-1:0];
    end

    ent_we    = ctrl.clear || wr_en;
    ent_wdata = ctrl.clear ? '0 : {entry_base_i, entry_check_i};
  end

  // base and check share one word; this memory is swept clear after reset
  dat_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .addr_i (mem_addr),
    .wdata_i(ent_wdata),
    .rdata_o(ent_rdata)
  );

  dat_ram #(
    .WIDTH(DATA_ID_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_did_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .addr_i (mem_addr),
    .wdata_i(entry_data_id_i),
    .rdata_o(did_rdata)
  );

  // --- response cycle: evaluate the target entry ------------------------------
  always_comb begin
    rd_base  = ent_rdata[EW-1:CW];
    rd_check = ent_rdata[CW-1:0];
    hit      = (cmd_q == dat_pkg::CMD_STEP) && tgt_ok_q && (PW'(rd_check) == pos_q);
    word_end = hit && rd_base[BW-1];

    pos_d       = pos_q;
    cur_base_d  = cur_base_q;
    root_base_d = root_base_q;

    // writes keep the cached bases coherent with the memory
    if (wr_en && (PW'(entry_index_i) == pos_q)) begin
      cur_base_d = entry_base_i;
    end
    if (wr_en && (entry_index_i == dat_pkg::ROOT_SLOT)) begin
      root_base_d = entry_base_i;
    end

    if (ctrl.resp && (cmd_q == dat_pkg::CMD_STEP)) begin
      if (hit) begin
        pos_d      = tgt_q;
        cur_base_d = rd_base;
      end else begin
        pos_d      = PW'(dat_pkg::ROOT_SLOT);
        cur_base_d = root_base_q;
      end
    end
  end

  always_comb begin
    if (cmd_q == dat_pkg::CMD_WRITE) begin
      status_o = dat_pkg::STATUS_WRITE_DONE;
    end else if (!hit) begin
      status_o = dat_pkg::STATUS_MISS;
    end else if (word_end) begin
      status_o = dat_pkg::STATUS_WORD_END;
    end else begin
      status_o = dat_pkg::STATUS_INNER;
    end
  end

  assign done_o          = ctrl.resp;
  assign busy            = ctrl.busy;
  assign position_o      = pos_d[dat_pkg::POS_W-1:0];
  assign found_data_id_o = (ctrl.resp && word_end) ? did_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PW'(dat_pkg::ROOT_SLOT);
      cur_base_q  <= '0;
      root_base_q <= '0;
    end else begin
      pos_q       <= pos_d;
      cur_base_q  <= cur_base_d;
      root_base_q <= root_base_d;
    end
  end

  // command capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      cmd_q    <= command_i;
      tgt_ok_q <= tgt_ok;
      tgt_q    <= tgt_ext[PW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dat_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dat_chk
// Port-level checks for the trie step block, bound onto the top level.
// ----------------------------------------------------------------------------
module dat_chk #(
  parameter int DATA_ID_WIDTH = 24
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           command_i,
  input wire logic                           done_o,
  input wire logic [dat_pkg::STAT_W-1:0]     status_o,
  input wire logic [dat_pkg::POS_W-1:0]      position_o,
  input wire logic [DATA_ID_WIDTH-1:0]       found_data_id_o
);

  // each accepted transfer is answered on the very next cycle
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted command not answered");

  // no result without a preceding accepted transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without command");

  // writes answer write-done, steps never do
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (($past(command_i) == dat_pkg::CMD_WRITE) ==
                (status_o == dat_pkg::STATUS_WRITE_DONE)))
    else $error("status does not match command");

  // a failed step returns to the root
  a_miss_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == dat_pkg::STATUS_MISS) |-> position_o == dat_pkg::ROOT_SLOT)
    else $error("miss did not return to root");

  // data id only reported on a word end
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != dat_pkg::STATUS_WORD_END) |-> found_data_id_o == '0)
    else $error("data id reported without word end");

endmodule

bind double_array_trie_step dat_chk #(
  .DATA_ID_WIDTH(DATA_ID_WIDTH)
) u_dat_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .position_o     (position_o),
  .found_data_id_o(found_data_id_o)
);
`default_nettype wire

FILE: tb/sv/tb_double_array_trie_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_array_trie_step
// Self-checking bench for the double-array trie walker. A short table of hand
// picked commands comes first, then random trie growth and walks. A
// behavioural copy of the trie predicts the results that the table does not
// fix; a checker compares each done_o strobe with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_double_array_trie_step;

  localparam int DEPTH       = 4096;
  localparam int CODE_W      = 8;
  localparam int ID_W        = 24;
  localparam int RANDOM_CMDS = 1430;
  localparam int IDLE_LIMIT  = 20000;  // covers the clear sweep and the longest random gap

  localparam int INDEX_W = dat_pkg::INDEX_W;
  localparam int BASE_W  = dat_pkg::BASE_W;
  localparam int CHECK_W = dat_pkg::CHECK_W;
  localparam int POS_W   = dat_pkg::POS_W;
  localparam int STAT_W  = dat_pkg::STAT_W;

  // one command as presented on the input ports
  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] index;
    logic [BASE_W-1:0]  base;
    logic [CHECK_W-1:0] check;
    logic [ID_W-1:0]    data_id;
    logic [CODE_W-1:0]  code;
  } trie_cmd_t;

  // one result as seen on the output ports
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [ID_W-1:0]   id;
  } trie_result_t;

  // row of the directed table; fixed_res is used when has_fixed is set
  typedef struct packed {
    trie_cmd_t    cmd;
    logic         has_fixed;
    trie_result_t fixed_res;
  } trie_row_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      start           = 1'b0;
  logic                      command_i       = dat_pkg::CMD_WRITE;
  logic        [INDEX_W-1:0] entry_index_i   = '0;
  logic signed [BASE_W-1:0]  entry_base_i    = '0;
  logic        [CHECK_W-1:0] entry_check_i   = '0;
  logic        [ID_W-1:0]    entry_data_id_i = '0;
  logic        [CODE_W-1:0]  symbol_code_i   = '0;
  logic                      busy;
  logic                      done_o;
  logic        [STAT_W-1:0]  status_o;
  logic        [POS_W-1:0]   position_o;
  logic        [ID_W-1:0]    found_data_id_o;

  // predictor's copy of the trie
  logic [BASE_W-1:0]  base_mem  [DEPTH];
  logic [CHECK_W-1:0] check_mem [DEPTH];
  logic [ID_W-1:0]    id_mem    [DEPTH];
  logic [POS_W-1:0]   walk_pos;

  trie_result_t pending_results[$];
  trie_row_t    directed_rows[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  int unsigned  burst_left;

  double_array_trie_step #(
    .TABLE_DEPTH   (DEPTH),
    .CODE_WIDTH    (CODE_W),
    .DATA_ID_WIDTH (ID_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .entry_base_i    (entry_base_i),
    .entry_check_i   (entry_check_i),
    .entry_data_id_i (entry_data_id_i),
    .symbol_code_i   (symbol_code_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .position_o      (position_o),
    .found_data_id_o (found_data_id_o)
  );

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // |base| taken as an unsigned 13-bit value, so the most negative base
  // comes out as 4096 rather than wrapping
  function automatic int unsigned base_mag(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] m;
    m = b[BASE_W-1] ? (~b + 1'b1) : b;
    return int'(m);
  endfunction

  // Applies one accepted command to the trie copy and returns its result.
  function automatic trie_result_t walk_trie(input trie_cmd_t c);
    trie_result_t r;
    int unsigned  tgt;
    r.id = '0;
    if (c.command == dat_pkg::CMD_WRITE) begin
      // every 12-bit index is inside the table
      base_mem[c.index]  = c.base;
      check_mem[c.index] = c.check;
      id_mem[c.index]    = c.data_id;
      r.status = dat_pkg::STATUS_WRITE_DONE;
    end else begin
      tgt = base_mag(base_mem[walk_pos]) + c.code;
      if (tgt >= DEPTH || check_mem[tgt] != walk_pos) begin
        // out of table or foreign slot: back to the root
        walk_pos = dat_pkg::ROOT_SLOT;
        r.status = dat_pkg::STATUS_MISS;
      end else begin
        walk_pos = tgt[POS_W-1:0];
        if (base_mem[tgt][BASE_W-1]) begin
          r.status = dat_pkg::STATUS_WORD_END;
          r.id     = id_mem[tgt];
        end else begin
          r.status = dat_pkg::STATUS_INNER;
        end
      end
    end
    r.pos = walk_pos;
    return r;
  endfunction

  // Random command shaped so that walks get past the root most of the time:
  // writes mostly hang a child under the current node or the root, steps
  // mostly pick a code that leads to an existing child.
  function automatic trie_cmd_t random_cmd();
    trie_cmd_t        c;
    int unsigned      roll;
    int unsigned      tgt;
    int unsigned      off;
    logic [POS_W-1:0] parent;
    logic [CODE_W-1:0] code;
    c.command = dat_pkg::CMD_STEP;
    c.index   = INDEX_W'($urandom_range(DEPTH - 1));
    c.base    = BASE_W'($urandom);
    c.check   = CHECK_W'($urandom_range(DEPTH - 1));
    c.data_id = ID_W'($urandom);
    c.code    = CODE_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 25) begin
      c.command = dat_pkg::CMD_WRITE;
      parent    = $urandom_range(1) ? walk_pos : dat_pkg::ROOT_SLOT;
      tgt       = base_mag(base_mem[parent]) + c.code;
      if (tgt < DEPTH) c.index = tgt[INDEX_W-1:0];
      c.check = parent;
      // keep most bases small enough that children still fit in the table
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: c.base = BASE_W'($urandom_range(3800));
        6, 7, 8:          c.base = -BASE_W'($urandom_range(3800, 1));
        default:          c.base = BASE_W'($urandom);
      endcase
    end else if (roll < 33) begin
      c.command = dat_pkg::CMD_WRITE;  // noise write, fields fully random
    end else if (roll < 88) begin
      off = $urandom_range(255);
      for (int k = 0; k < 256; k++) begin
        code = CODE_W'(off + k);
        tgt  = base_mag(base_mem[walk_pos]) + code;
        if (tgt < DEPTH && check_mem[tgt] == walk_pos) begin
          c.code = code;
          break;
        end
      end
    end
    return c;
  endfunction

  // Drives one command after a random gap and holds it until taken. On
  // return the command has been transferred and its result is queued.
  task automatic transfer_cmd(input trie_cmd_t c, input logic has_fixed,
                              input trie_result_t fixed_res);
    int unsigned  gap;
    int unsigned  roll;
    trie_result_t predicted;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        burst_left = $urandom_range(60, 20);
        gap = 0;
      end else if (roll < 45) gap = 0;
      else if (roll < 90)     gap = $urandom_range(3, 1);
      else                    gap = $urandom_range(40, 8);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i       <= c.command;
    entry_index_i   <= c.index;
    entry_base_i    <= c.base;
    entry_check_i   <= c.check;
    entry_data_id_i <= c.data_id;
    symbol_code_i   <= c.code;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = walk_trie(c);
    pending_results.push_back(has_fixed ? fixed_res : predicted);
  endtask

  // directed table entry; fixed result only where it is obvious
  function automatic void add_row(input logic cmd, input int idx, input int b,
                                  input int chk, input int id, input int code,
                                  input logic fixed = 1'b0,
                                  input logic [STAT_W-1:0] st = dat_pkg::STATUS_MISS,
                                  input int pos = 1);
    trie_row_t r;
    r.cmd.command    = cmd;
    r.cmd.index      = INDEX_W'(idx);
    r.cmd.base       = BASE_W'(b);
    r.cmd.check      = CHECK_W'(chk);
    r.cmd.data_id    = ID_W'(id);
    r.cmd.code       = CODE_W'(code);
    r.has_fixed      = fixed;
    r.fixed_res      = '0;
    r.fixed_res.status = st;
    r.fixed_res.pos  = POS_W'(pos);
    directed_rows.push_back(r);
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk_i) begin : result_check
    trie_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (position_o !== want.pos) begin
          report_mismatch("position", 32'(position_o), 32'(want.pos));
        end
        if (found_data_id_o !== want.id) begin
          report_mismatch("found_data_id", 32'(found_data_id_o), 32'(want.id));
        end
      end
    end
  end

  // Watchdog: cycles with neither a command transfer nor a result.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("** double_array_trie_step: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    for (int i = 0; i < DEPTH; i++) begin
      base_mem[i]  = '0;
      check_mem[i] = '0;
      id_mem[i]    = '0;
    end
    walk_pos = dat_pkg::ROOT_SLOT;

    // Directed part. Small trie: root base 10; code 2 -> slot 12 (inner),
    // then code 5 -> slot 25 (word end with children); code 30 -> slot 40
    // with the most negative base; code 40 -> slot 50 with the largest base;
    // code 10 -> slot 20, a word end with data id zero.
    // empty table: both extremes of the code miss
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   0, 1'b1, dat_pkg::STATUS_MISS, 1);
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0, 255, 1'b1, dat_pkg::STATUS_MISS, 1);
    // field extremes on writes
    add_row(dat_pkg::CMD_WRITE, 0,     4095, 4095, 24'hFFFFFF, 0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 4095, -4095, 0,        0,   0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 1,     10,   0,  24'h123456, 0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 12,    20,   1,        0,   0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 25,   -30,   12, 24'hFFFFFF, 0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 31,    0,    25,       5,   0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 40,   -4096, 1,  24'hABCDEF, 0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 50,    4095, 1,        0,   0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_WRITE, 20,   -1,    1,        0,   0, 1'b1,
            dat_pkg::STATUS_WRITE_DONE, 1);
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   2);   // inner node
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   5);   // word end, max data id
    add_row(dat_pkg::CMD_WRITE, 100,   0,    0,        0,   0);   // write away from the root
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   1);   // child below a word end
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   0);   // check mismatch
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,  30);   // most negative base
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   0);   // |base| 4096: out of table
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,  40);   // largest base
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0, 255);   // target past the end
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,  10);   // word end, data id zero
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   3);   // miss from a word end
    add_row(dat_pkg::CMD_STEP,  0,     0,    0,        0,   3);   // miss from the root

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      transfer_cmd(directed_rows[i].cmd, directed_rows[i].has_fixed,
                   directed_rows[i].fixed_res);
    for (int n = 0; n < RANDOM_CMDS; n++)
      transfer_cmd(random_cmd(), 1'b0, '0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** double_array_trie_step: PASSED **");
    end else begin
      $display("** double_array_trie_step: FAILED **");
    end
    $finish;
  end

endmodule
